// ===== rtl/gfalu_pkg.sv =====
package gfalu_pkg;

   localparam int OP_W    = 8;
   localparam int POLY_W  = OP_W + 1;
   localparam int VAL_W   = 2 * OP_W - 1;
   localparam int REM_W   = OP_W;
   localparam int CMD_W   = 3;
   localparam int CHAIN_W = VAL_W;
   localparam int CNT_W   = $clog2(CHAIN_W);

   localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(283);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 3'd0,
      CMD_MUL    = 3'd1,
      CMD_INV    = 3'd2,
      CMD_DIVIDE = 3'd3,
      CMD_CLMUL  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic xor_en;
   } cell_ctrl_type;

   // degree of a polynomial, zero for the zero polynomial
   function automatic logic [CNT_W-1:0] deg_of(input logic [CHAIN_W-1:0] p);
      logic [CNT_W-1:0] d;
      d = '0;
      for (int i = 1; i < CHAIN_W; i++) begin
         if (p[i]) d = CNT_W'(i);
      end
      return d;
   endfunction

endpackage

// ===== rtl/gfalu_cell.sv =====
module gfalu_cell (
   input  logic                     clock,
   input  gfalu_pkg::cell_ctrl_type ctrl,
   input  logic                     n_load,
   input  logic                     ds_load,
   input  logic                     ds_left,
   output logic                     n_q,
   output logic                     ds_q
);
   import gfalu_pkg::*;

   logic n_ff;
   logic ds_ff;

   // one coefficient of the working polynomial and of the shifted operand
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         n_ff  <= n_load;
         ds_ff <= ds_load;
      end else if (ctrl.step) begin
         ds_ff <= ds_left;
         if (ctrl.xor_en) n_ff <= n_ff ^ ds_ff;
      end
   end

   assign n_q  = n_ff;
   assign ds_q = ds_ff;

endmodule

// ===== rtl/gf2_polynomial_field_alu.sv =====
// Binary polynomial / GF(2^8) arithmetic unit. Commands: field add, field multiply,
// field inverse (extended Euclid), polynomial divide and raw carry-less multiply; the
// reduction polynomial is set through the csr port (reset x^8+x^4+x^3+x+1) and may
// only be written while the unit is idle. All work runs on one row of 15 bit cells
// that shift an aligned operand right by one place per cycle and xor it in where a
// leading or multiplier bit says so. A divide pass steps through the quotient bits
// and a multiply pass through the multiplier bits, each with a closing step, and
// each result then goes through the result register to the output register. Field
// add and divide use one divide pass, carry-less multiply one multiply pass, field
// multiply a multiply then a divide pass, an inverse a divide and multiply pass per
// Euclid round. One item is in work at a time; a finished beat waits in the output
// register while the next item is taken. Errors (zero polynomial, divide by zero,
// no inverse, unused command) give error set with value and remainder zero.
module gf2_polynomial_field_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [gfalu_pkg::POLY_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gfalu_pkg::CMD_W-1:0]   req_cmd,
   input  logic [gfalu_pkg::OP_W-1:0]    req_operand_a,
   input  logic [gfalu_pkg::OP_W-1:0]    req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gfalu_pkg::VAL_W-1:0]   rsp_value,
   output logic [gfalu_pkg::REM_W-1:0]   rsp_remainder,
   output logic                          rsp_error
);
   import gfalu_pkg::*;

   state_type state_ff, state_in;
   cmd_type   op_ff, op_in;
   logic [POLY_W-1:0]  poly_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, lo_ff, lo_in, dq_ff, dq_in;
   logic               over_ff, over_in;
   logic [CHAIN_W-1:0] q_ff, q_in;
   logic [POLY_W-1:0]  rp_ff, rp_in, rc_ff, rc_in, tp_ff, tp_in, tc_ff, tc_in;
   logic [VAL_W-1:0]   res_val_ff, res_val_in;
   logic [REM_W-1:0]   res_rem_ff, res_rem_in;
   logic               res_err_ff, res_err_in;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_val_ff;
   logic [REM_W-1:0]   rsp_rem_ff;
   logic               rsp_err_ff;

   cell_ctrl_type      ctrl;
   logic [CHAIN_W-1:0] ld_n, ld_ds, chain_n, chain_ds;

   logic [CHAIN_W-1:0] dsrc_n, dsrc_d, div_ds, ab_ds, inv_ds;
   logic [CNT_W-1:0]   deg_n, deg_d, div_sh;
   logic               div_fits;
   logic [POLY_W-1:0]  a_ext, inv_big, inv_small;
   logic               acc_err, acc_mul;
   logic               div_run, out_free;

   // ---------------- cell row ----------------
   for (genvar i = 0; i < CHAIN_W; i++) begin : g_cell
      logic left;
      if (i == CHAIN_W - 1) begin : g_top
         assign left = 1'b0;
      end else begin : g_mid
         assign left = chain_ds[i+1];
      end
      gfalu_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .n_load  (ld_n[i]),
         .ds_load (ld_ds[i]),
         .ds_left (left),
         .n_q     (chain_n[i]),
         .ds_q    (chain_ds[i])
      );
   end

   // ---------------- operand selection ----------------
   assign a_ext     = POLY_W'(req_operand_a);
   assign inv_big   = (a_ext > poly_ff) ? a_ext : poly_ff;
   assign inv_small = (a_ext > poly_ff) ? poly_ff : a_ext;

   always_comb begin
      dsrc_n = CHAIN_W'(req_operand_a);
      dsrc_d = CHAIN_W'(poly_ff);
      if (state_ff == ST_IDLE) begin
         unique case (req_cmd)
            CMD_ADD:    dsrc_n = CHAIN_W'(req_operand_a ^ req_operand_b);
            CMD_INV: begin
               dsrc_n = CHAIN_W'(inv_big);
               dsrc_d = CHAIN_W'(inv_small);
            end
            CMD_DIVIDE: dsrc_d = CHAIN_W'(req_operand_b);
            default:    dsrc_d = CHAIN_W'(poly_ff);
         endcase
      end else if (op_ff == CMD_INV) begin
         dsrc_n = CHAIN_W'(rp_ff);
         dsrc_d = CHAIN_W'(rc_ff);
      end else begin
         dsrc_n = chain_n;
      end
   end

   assign deg_n    = deg_of(dsrc_n);
   assign deg_d    = deg_of(dsrc_d);
   assign div_fits = deg_n >= deg_d;
   assign div_sh   = deg_n - deg_d;
   assign div_ds   = div_fits ? (dsrc_d << div_sh) : dsrc_d;
   assign ab_ds    = {req_operand_a, (OP_W-1)'(0)};
   assign inv_ds   = CHAIN_W'(tc_ff) << dq_ff;

   always_comb begin
      acc_err = 1'b1;
      acc_mul = 1'b0;
      unique case (req_cmd)
         CMD_ADD:    acc_err = poly_ff == '0;
         CMD_MUL: begin
            acc_err = poly_ff == '0;
            acc_mul = 1'b1;
         end
         CMD_INV:    acc_err = inv_small == '0;
         CMD_DIVIDE: acc_err = req_operand_b == '0;
         CMD_CLMUL: begin
            acc_err = 1'b0;
            acc_mul = 1'b1;
         end
         default:    acc_err = 1'b1;
      endcase
   end

   assign div_run  = !over_ff && (cnt_ff >= lo_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (acc_err) state_in = ST_DONE;
               else if (acc_mul)     state_in = ST_MUL;
               else                  state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_run) begin
               if (op_ff == CMD_INV && chain_n != '0) state_in = ST_MUL;
               else                                   state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            if (over_ff) begin
               if (op_ff == CMD_CLMUL) state_in = ST_DONE;
               else                    state_in = ST_DIV;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath control ----------------
   always_comb begin
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      lo_in      = lo_ff;
      dq_in      = dq_ff;
      over_in    = over_ff;
      q_in       = q_ff;
      rp_in      = rp_ff;
      rc_in      = rc_ff;
      tp_in      = tp_ff;
      tc_in      = tc_ff;
      res_val_in = res_val_ff;
      res_rem_in = res_rem_ff;
      res_err_in = res_err_ff;
      ctrl       = '0;
      ld_n       = dsrc_n;
      ld_ds      = div_ds;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = cmd_type'(req_cmd);
               over_in = 1'b0;
               rp_in   = inv_big;
               rc_in   = inv_small;
               tp_in   = '0;
               tc_in   = POLY_W'(1);
               priority if (acc_err) begin
                  res_val_in = '0;
                  res_rem_in = '0;
                  res_err_in = 1'b1;
               end else if (acc_mul) begin
                  ctrl.load = 1'b1;
                  ld_n      = '0;
                  ld_ds     = ab_ds;
                  cnt_in    = CNT_W'(OP_W - 1);
                  q_in      = CHAIN_W'(req_operand_b);
               end else begin
                  ctrl.load = 1'b1;
                  cnt_in    = deg_n;
                  lo_in     = deg_d;
                  dq_in     = div_fits ? div_sh : '0;
                  q_in      = '0;
               end
            end
         end
         ST_DIV: begin
            if (div_run) begin
               ctrl.step   = 1'b1;
               ctrl.xor_en = chain_n[cnt_ff];
               q_in        = {q_ff[CHAIN_W-2:0], chain_n[cnt_ff]};
               if (cnt_ff == lo_ff) over_in = 1'b1;
               else                 cnt_in  = cnt_ff - 1'b1;
            end else begin
               over_in    = 1'b0;
               res_val_in = chain_n;
               res_rem_in = '0;
               res_err_in = 1'b0;
               unique case (op_ff)
                  CMD_INV: begin
                     if (chain_n == '0) begin
                        if (rc_ff == POLY_W'(1)) begin
                           res_val_in = VAL_W'(tc_ff);
                        end else begin
                           res_val_in = '0;
                           res_err_in = 1'b1;
                        end
                     end else begin
                        rp_in     = rc_ff;
                        rc_in     = chain_n[POLY_W-1:0];
                        ctrl.load = 1'b1;
                        ld_n      = CHAIN_W'(tp_ff);
                        ld_ds     = inv_ds;
                        cnt_in    = dq_ff;
                     end
                  end
                  CMD_DIVIDE: begin
                     res_val_in = q_ff;
                     res_rem_in = chain_n[REM_W-1:0];
                  end
                  default: res_rem_in = '0;
               endcase
            end
         end
         ST_MUL: begin
            if (!over_ff) begin
               ctrl.step   = 1'b1;
               ctrl.xor_en = q_ff[cnt_ff];
               if (cnt_ff == '0) over_in = 1'b1;
               else              cnt_in  = cnt_ff - 1'b1;
            end else begin
               over_in = 1'b0;
               if (op_ff == CMD_CLMUL) begin
                  res_val_in = chain_n;
                  res_rem_in = '0;
                  res_err_in = 1'b0;
               end else begin
                  if (op_ff == CMD_INV) begin
                     tp_in = tc_ff;
                     tc_in = chain_n[POLY_W-1:0];
                  end
                  ctrl.load = 1'b1;
                  cnt_in    = deg_n;
                  lo_in     = deg_d;
                  dq_in     = div_fits ? div_sh : '0;
                  q_in      = '0;
               end
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_ff      <= POLY_RESET;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         over_ff  <= over_in;
         if (csr_write_enable) poly_ff <= csr_write_data;
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                  rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cnt_ff     <= cnt_in;
      lo_ff      <= lo_in;
      dq_ff      <= dq_in;
      q_ff       <= q_in;
      rp_ff      <= rp_in;
      rc_ff      <= rc_in;
      tp_ff      <= tp_in;
      tc_ff      <= tc_in;
      res_val_ff <= res_val_in;
      res_rem_ff <= res_rem_in;
      res_err_ff <= res_err_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_val_ff <= res_val_ff;
         rsp_rem_ff <= res_rem_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   assign req_ready     = state_ff == ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_val_ff;
   assign rsp_remainder = rsp_rem_ff;
   assign rsp_error     = rsp_err_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_MUL) |-> cnt_ff < CNT_W'(CHAIN_W))
      else $error("step index out of chain");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_value == '0 && rsp_remainder == '0))
      else $error("error beat carries data");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE)
      else $error("accepted beat dropped");

   a_done_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid)
      else $error("result not presented");
`endif

endmodule
